>>> design/tlvpp_pkg.sv
// Shared types and constants for the TLV response unpad parser.
package tlvpp_pkg;

  // Parse position within one response.
  typedef enum logic [3:0] {
    PH_OUTER_TAG = 4'd0,
    PH_OUTER_LEN = 4'd1,
    PH_OUTER_EXT = 4'd2,
    PH_INNER_TAG = 4'd3,
    PH_INNER_LEN = 4'd4,
    PH_INNER_EXT = 4'd5,
    PH_HDR0      = 4'd6,
    PH_HDR1      = 4'd7,
    PH_PAD       = 4'd8,
    PH_PAYLOAD   = 4'd9,
    PH_ERROR     = 4'd10
  } phase_t;

  // End status reported on the beat marked last.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_OUTER = 3'd1,
    ST_BAD_INNER = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_NO_SEP    = 3'd4,
    ST_TRUNC     = 3'd5
  } status_t;

  localparam logic [7:0] OUTER_TAG    = 8'h7c;
  localparam logic [7:0] INNER_TAG    = 8'h82;
  localparam logic [7:0] LEN_LONG1    = 8'h81;
  localparam logic [7:0] LEN_LONG2    = 8'h82;
  localparam logic [7:0] PAD_TYPE2    = 8'h02;

  localparam int unsigned OUT_DATA_W  = 16;

endpackage

>>> design/tlv_response_pkcs1_unpad_parser_unit.sv
// Top level of the TLV response parser with PKCS#1 v1.5 type-2 unpadding.
//
// Input channel s_axis_*: one response byte per beat, tlast on the final byte.
// The parser checks outer tag 0x7c and its BER length, inner tag 0x82 and its
// BER length, the 00 02 padding header, then skips nonzero padding up to the
// first zero byte. Each later byte leaves on m_axis_* with tuser high. The beat
// for the input byte marked last carries tlast and the end status in tdata;
// other header and padding bytes produce no output beat. After an error the
// rest of the response is dropped and its code is reported at the last byte.
//
// The output is registered: a result is in the output register the cycle after
// its byte is accepted. Throughput is one byte per cycle while the receiver
// keeps up. s_axis_tready is high while the output register is empty or being
// drained this cycle, so a stalled receiver holds the output beat and backs up
// the input after one stored beat.
// Reset (rst, synchronous) returns the parser to the outer-tag phase and
// empties the output register. After every last byte the parser restarts too.
module tlv_response_pkcs1_unpad_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] rx_byte
  input  logic                                 s_axis_tlast,  // last
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] out_byte, [10:8] end_status, [15:11] zero
  output logic [tlvpp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tuser,  // payload_valid
  output logic                                 m_axis_tlast   // is_end
);
  import tlvpp_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  len_left, len_left_next;
  status_t     err, err_next;

  logic        accept;
  logic        emit;
  status_t     status;

  logic [7:0]  out_byte;
  status_t     out_status;
  logic        out_valid;
  logic        out_payload;
  logic        out_end;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next parse state for the byte on the input.
  always_comb begin
    phase_next    = phase;
    len_left_next = len_left;
    err_next      = err;
    emit          = 1'b0;
    case (phase)
      PH_OUTER_TAG: begin
        if (s_axis_tdata == OUTER_TAG) begin
          phase_next = PH_OUTER_LEN;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ST_BAD_OUTER;
        end
      end
      PH_OUTER_LEN, PH_INNER_LEN: begin
        if (s_axis_tdata == LEN_LONG1) begin
          len_left_next = 2'd1;
          phase_next    = (phase == PH_OUTER_LEN) ? PH_OUTER_EXT : PH_INNER_EXT;
        end else if (s_axis_tdata == LEN_LONG2) begin
          len_left_next = 2'd2;
          phase_next    = (phase == PH_OUTER_LEN) ? PH_OUTER_EXT : PH_INNER_EXT;
        end else begin
          phase_next    = (phase == PH_OUTER_LEN) ? PH_INNER_TAG : PH_HDR0;
        end
      end
      PH_OUTER_EXT, PH_INNER_EXT: begin
        if (len_left > 2'd1) begin
          len_left_next = len_left - 2'd1;
        end else begin
          len_left_next = 2'd0;
          phase_next    = (phase == PH_OUTER_EXT) ? PH_INNER_TAG : PH_HDR0;
        end
      end
      PH_INNER_TAG: begin
        if (s_axis_tdata == INNER_TAG) begin
          phase_next = PH_INNER_LEN;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ST_BAD_INNER;
        end
      end
      PH_HDR0: begin
        if (s_axis_tdata == 8'h00) begin
          phase_next = PH_HDR1;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ST_BAD_HDR;
        end
      end
      PH_HDR1: begin
        if (s_axis_tdata == PAD_TYPE2) begin
          phase_next = PH_PAD;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ST_BAD_HDR;
        end
      end
      PH_PAD: begin
        if (s_axis_tdata == 8'h00) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // End status from the phase reached after this byte.
  always_comb begin
    case (phase_next)
      PH_ERROR:   status = err_next;
      PH_PAYLOAD: status = ST_OK;
      PH_PAD:     status = ST_NO_SEP;
      default:    status = ST_TRUNC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OUTER_TAG;
      len_left <= 2'd0;
      err      <= ST_OK;
    end else if (accept) begin
      if (s_axis_tlast) begin
        // restart for the next response
        phase    <= PH_OUTER_TAG;
        len_left <= 2'd0;
        err      <= ST_OK;
      end else begin
        phase    <= phase_next;
        len_left <= len_left_next;
        err      <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit || s_axis_tlast;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte    <= emit ? s_axis_tdata : 8'h00;
      out_payload <= emit;
      out_end     <= s_axis_tlast;
      out_status  <= s_axis_tlast ? status : ST_OK;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000, out_status, out_byte};
  assign m_axis_tuser  = out_payload;
  assign m_axis_tlast  = out_end;

endmodule

>>> design/tlvpp_checker.sv
// Port-level checker for the TLV response parser, bound to the top level.
module tlvpp_assertions (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import tlvpp_pkg::*;

  // Every output beat is a payload byte or an end report.
  a_beat_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
    else $error("output beat is neither payload nor end");

  // Non-payload beats carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("non-payload beat carries data");

  // Status only on the end beat.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[10:8] == ST_OK))
    else $error("status set on a beat that is not last");

  // A payload byte can only come after the separator, so its end is ok.
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser && m_axis_tlast) |-> (m_axis_tdata[10:8] == ST_OK))
    else $error("payload on last beat with error status");

  // Hold a stalled beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

endmodule

bind tlv_response_pkcs1_unpad_parser_unit tlvpp_assertions u_tlvpp_assertions (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
